[src/wpfm_pkg.sv]
// ----------------------------------------------------------------------------
// wpfm_pkg: shared types and constants
// Word types of both channels, the root unit request/response and the
// register map of the windowed peak force magnitude block.
// ----------------------------------------------------------------------------
package wpfm_pkg;

	localparam int ACCEL_W = 16;
	localparam int FORCE_W = 26;
	localparam int MAG_W   = 16;
	localparam int GAIN_W  = 10;
	localparam int LEN_W   = 16;
	localparam int PEAK_W  = 32;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	localparam logic [GAIN_W-1:0] MASS_GAIN_RST  = 10'd65;
	localparam logic [LEN_W-1:0]  WINDOW_LEN_RST = 16'd500;

	// register index (paddr[2])
	localparam logic REG_MASS_GAIN  = 1'b0;
	localparam logic REG_WINDOW_LEN = 1'b1;

	localparam logic [PEAK_W-1:0] ROOT_BIT_INIT = 32'h4000_0000;

	typedef struct packed {
		logic signed [ACCEL_W-1:0] accel_x;
		logic signed [ACCEL_W-1:0] accel_y;
	} in_word_t;

	typedef struct packed {
		logic [FORCE_W-1:0] peak_force;
		logic [MAG_W-1:0]   peak_magnitude;
	} out_word_t;

	typedef struct packed {
		logic              start;
		logic [PEAK_W-1:0] radicand;
	} root_req_t;

	typedef struct packed {
		logic             done;
		logic [MAG_W-1:0] root;
	} root_rsp_t;

endpackage

[src/wpfm_isqrt.sv]
// ----------------------------------------------------------------------------
// wpfm_isqrt: iterative integer square root
// Digit-by-digit root of a 32-bit radicand, one result bit per cycle through
// a single subtract/compare.
// ----------------------------------------------------------------------------
module wpfm_isqrt import wpfm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  root_req_t req,
	output root_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [PEAK_W-1:0] rem_q;
	logic [PEAK_W-1:0] root_q;
	logic [PEAK_W-1:0] bit_q;
	logic [PEAK_W:0]   cand;
	logic              take;

	assign cand = {1'b0, root_q} + {1'b0, bit_q};
	assign take = {1'b0, rem_q} >= cand;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rem_q  <= '0;
			root_q <= '0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				rem_q  <= req.radicand;
				root_q <= '0;
				bit_q  <= ROOT_BIT_INIT;
			end else if (busy_q) begin
				if (take) begin
					rem_q  <= rem_q - cand[PEAK_W-1:0];
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q[MAG_W-1:0];

endmodule

[src/windowed_peak_force_magnitude_top.sv]
// ----------------------------------------------------------------------------
// windowed_peak_force_magnitude_top: windowed peak of |(x, y)| times mass
// Input words carry one signed X/Y accelerometer pair; the largest x*x+y*y
// of each window is kept and, after window_len words, one output word gives
// its integer root and mass_gain times that root.
//
// Channels: in (valid/ready, in_word_t), out (valid/ready, out_word_t) and an
// APB register port: mass_gain at 0x0, window_len at 0x4, pready tied high.
// Timing: in_ready drops after each accepted word while one shared
// multiplier forms x*x, then y*y, then the peak compare runs; the next word
// is taken only once that compare is done. A word that closes the window
// then passes the bit-serial root unit, ST_ROOT to collect the root, scaling
// on the same multiplier in ST_SCALE and ST_EMIT to load the output register;
// in_ready comes back as out_valid rises.
// The output register holds a finished word while out_ready is low; further
// input words are still taken meanwhile, and only a second window end waits.
// Reset (arst_n low) clears peak and count, loads mass_gain 65 and
// window_len 500 and empties the output register.
// ----------------------------------------------------------------------------
module windowed_peak_force_magnitude_top import wpfm_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_word_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_word_t         out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int RAW_W = (SAMPLE_BITS > ACCEL_W) ? SAMPLE_BITS : ACCEL_W;
	localparam int MW    = (SAMPLE_BITS > MAG_W) ? SAMPLE_BITS : MAG_W;
	localparam int SQW   = 2 * SAMPLE_BITS + 1;
	localparam int SQE_W = (SQW > PEAK_W + 1) ? SQW : PEAK_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SQX, ST_SQY, ST_PEAK, ST_ROOT, ST_SCALE, ST_EMIT
	} state_t;

	state_t                 state_q;
	logic [GAIN_W-1:0]      gain_q;
	logic [LEN_W-1:0]       len_q;
	logic [SAMPLE_BITS-1:0] ax_q;
	logic [SAMPLE_BITS-1:0] ay_q;
	logic [SQW-1:0]         sq_q;
	logic [PEAK_W-1:0]      peak_q;
	logic [LEN_W-1:0]       count_q;
	logic [MAG_W-1:0]       mag_q;
	logic [FORCE_W-1:0]     force_q;
	logic                   out_valid_q;
	out_word_t              out_data_q;

	logic [RAW_W-1:0]       raw_x;
	logic [RAW_W-1:0]       raw_y;
	logic [SAMPLE_BITS-1:0] sx;
	logic [SAMPLE_BITS-1:0] sy;
	logic [SAMPLE_BITS-1:0] abs_x;
	logic [SAMPLE_BITS-1:0] abs_y;
	logic [MW-1:0]          mul_a;
	logic [MW-1:0]          mul_b;
	logic [2*MW-1:0]        prod;
	logic [SQE_W-1:0]       sq_ext;
	logic [PEAK_W-1:0]      sq_sat;
	logic [PEAK_W-1:0]      peak_new;
	logic [LEN_W-1:0]       count_new;
	logic                   win_end;
	logic                   cfg_wr;
	root_req_t              root_req;
	root_rsp_t              root_rsp;

	// sample zero extension and magnitude
	assign raw_x = RAW_W'(unsigned'(in_data.accel_x));
	assign raw_y = RAW_W'(unsigned'(in_data.accel_y));
	assign sx    = raw_x[SAMPLE_BITS-1:0];
	assign sy    = raw_y[SAMPLE_BITS-1:0];
	assign abs_x = sx[SAMPLE_BITS-1] ? (~sx + 1'b1) : sx;
	assign abs_y = sy[SAMPLE_BITS-1] ? (~sy + 1'b1) : sy;

	// shared multiplier
	always_comb begin
		unique case (state_q)
			ST_SQX: begin
				mul_a = MW'(ax_q);
				mul_b = MW'(ax_q);
			end
			ST_SQY: begin
				mul_a = MW'(ay_q);
				mul_b = MW'(ay_q);
			end
			ST_SCALE: begin
				mul_a = MW'(gain_q);
				mul_b = MW'(mag_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign prod = mul_a * mul_b;

	assign sq_ext    = SQE_W'(sq_q);
	assign sq_sat    = (|sq_ext[SQE_W-1:PEAK_W]) ? '1 : sq_ext[PEAK_W-1:0];
	assign peak_new  = (sq_sat > peak_q) ? sq_sat : peak_q;
	assign count_new = count_q + 1'b1;
	assign win_end   = count_new >= len_q;

	assign root_req.start    = (state_q == ST_PEAK) && win_end;
	assign root_req.radicand = peak_new;

	wpfm_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (root_req),
		.rsp    (root_rsp)
	);

	// register port
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	always_comb begin
		unique case (paddr[2])
			REG_MASS_GAIN:  prdata = APB_DW'(gain_q);
			REG_WINDOW_LEN: prdata = APB_DW'(len_q);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= MASS_GAIN_RST;
			len_q  <= WINDOW_LEN_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_MASS_GAIN:  gain_q <= pwdata[GAIN_W-1:0];
				REG_WINDOW_LEN: len_q  <= pwdata[LEN_W-1:0];
				default:        ;
			endcase
		end
	end

	// datapath words
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				ax_q <= abs_x;
				ay_q <= abs_y;
			end
			ST_SQX:   sq_q <= SQW'(prod);
			ST_SQY:   sq_q <= sq_q + SQW'(prod);
			ST_ROOT:  mag_q <= root_rsp.root;
			ST_SCALE: force_q <= prod[FORCE_W-1:0];
			default:  ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			peak_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SQX;
					end
				end
				ST_SQX: state_q <= ST_SQY;
				ST_SQY: state_q <= ST_PEAK;
				ST_PEAK: begin
					if (win_end) begin
						peak_q  <= '0;
						count_q <= '0;
						state_q <= ST_ROOT;
					end else begin
						peak_q  <= peak_new;
						count_q <= count_new;
						state_q <= ST_IDLE;
					end
				end
				ST_ROOT: begin
					if (root_rsp.done) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q               <= 1'b1;
						out_data_q.peak_force     <= force_q;
						out_data_q.peak_magnitude <= mag_q;
						state_q                   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

[src/wpfm_checker.sv]
// ----------------------------------------------------------------------------
// wpfm_checker: port-level checks
// Watches the top level's ports for handshake and sequencing slips; bound to
// the top level below.
// ----------------------------------------------------------------------------
module wpfm_checker import wpfm_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_data
);

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	// busy straight after every accepted word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while still working");

	// ready only drops on an accepted word
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid && in_ready))
		else $error("in_ready dropped without a word");

	// a result never appears the cycle after acceptance
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("result raised too early");

endmodule

bind windowed_peak_force_magnitude_top wpfm_checker u_wpfm_checker (.*);
